[src/acfp_pkg.sv]
package acfp_pkg;

  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_C     = 8'h63;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;

  localparam logic [1:0] ADDR_DIGITS = 2'd2;
  localparam logic [1:0] CSUM_DIGITS = 2'd3;

  localparam logic [7:0] REG_DEVICE_ADDRESS = 8'd0;
  localparam logic [7:0] REG_TIMEOUT_TICKS  = 8'd1;

  localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd1;
  localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd100;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_ADDR,
    PH_CMD,
    PH_VALS,
    PH_CSUM,
    PH_EOL,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    DR_IDLE,
    DR_READ,
    DR_LOAD
  } drain_state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] command;
    logic [4:0] colon_count;
    logic       to_this_device;
  } frame_done_t;

  // dallas crc8, reflected, one byte
  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/acfp_mem.sv]
module acfp_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/acfp_parser.sv]
module acfp_parser #(
  parameter int MAX_VALUES = 16,
  parameter int CW         = 5,
  parameter int AW         = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 func,
  input  logic [7:0]           rx_byte,
  input  logic [6:0]           device_address,
  input  logic [15:0]          timeout_ticks,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [7:0]           mem_wdata,
  output acfp_pkg::frame_done_t done,
  output logic [CW-1:0]        value_count
);

  acfp_pkg::phase_t phase, phase_next;
  logic [15:0]   acc, acc_next;
  logic [1:0]    digits_left, digits_left_next;
  logic [7:0]    crc, crc_next;
  logic [7:0]    cmd, cmd_next;
  logic [CW-1:0] stored_count, stored_count_next;
  logic [CW-1:0] colons, colons_next;
  logic          addressed, addressed_next;
  logic [15:0]   idle_ticks, idle_ticks_next;

  logic          is_digit;
  logic [3:0]    digit;
  logic [19:0]   acc_x10d;
  logic [7:0]    crc_byte;
  logic          full;
  logic          is_sep;

  assign is_digit = (rx_byte >= acfp_pkg::CHAR_ZERO) && (rx_byte <= acfp_pkg::CHAR_NINE);
  assign digit    = rx_byte[3:0];
  assign acc_x10d = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, digit};
  assign crc_byte = acfp_pkg::crc8_add(crc, rx_byte);
  assign full     = stored_count >= CW'(MAX_VALUES);
  assign is_sep   = (rx_byte == acfp_pkg::CHAR_COLON) || (rx_byte == acfp_pkg::CHAR_COMMA);

  assign mem_waddr   = stored_count[AW-1:0];
  assign mem_wdata   = acc[7:0];
  assign value_count = stored_count;

  always_comb begin
    phase_next        = phase;
    acc_next          = acc;
    digits_left_next  = digits_left;
    crc_next          = crc;
    cmd_next          = cmd;
    stored_count_next = stored_count;
    colons_next       = colons;
    addressed_next    = addressed;
    idle_ticks_next   = idle_ticks;
    mem_we            = 1'b0;
    done.start          = 1'b0;
    done.command        = cmd;
    done.colon_count    = 5'(colons);
    done.to_this_device = addressed;
    if (accept && func) begin
      if (idle_ticks != acfp_pkg::TICK_MAX) begin
        idle_ticks_next = idle_ticks + 16'd1;
      end
      if (phase != acfp_pkg::PH_WAIT && idle_ticks_next >= timeout_ticks) begin
        phase_next = acfp_pkg::PH_WAIT;
      end
    end else if (accept) begin
      idle_ticks_next = '0;
      if (rx_byte == acfp_pkg::CHAR_AT) begin
        phase_next        = acfp_pkg::PH_ADDR;
        acc_next          = '0;
        digits_left_next  = acfp_pkg::ADDR_DIGITS;
        crc_next          = acfp_pkg::crc8_add(8'h00, rx_byte);
        cmd_next          = '0;
        stored_count_next = '0;
        colons_next       = '0;
        addressed_next    = 1'b0;
      end else begin
        case (phase)
          acfp_pkg::PH_ADDR: begin
            if (!is_digit) begin
              phase_next = acfp_pkg::PH_BAD;
            end else begin
              acc_next         = acc_x10d[15:0];
              crc_next         = crc_byte;
              digits_left_next = digits_left - 2'd1;
              if (digits_left_next == 2'd0) begin
                if (acc_next == 16'd0 || acc_next == {9'b0, device_address}) begin
                  addressed_next = acc_next == {9'b0, device_address};
                  phase_next     = acfp_pkg::PH_CMD;
                end else begin
                  phase_next = acfp_pkg::PH_BAD;
                end
              end
            end
          end
          acfp_pkg::PH_CMD: begin
            cmd_next         = rx_byte;
            crc_next         = crc_byte;
            acc_next         = '0;
            digits_left_next = '0;
            phase_next       = acfp_pkg::PH_VALS;
          end
          acfp_pkg::PH_VALS: begin
            if (is_sep || rx_byte == acfp_pkg::CHAR_C) begin
              if (full) begin
                phase_next = acfp_pkg::PH_BAD;
              end else begin
                mem_we            = 1'b1;
                stored_count_next = stored_count + CW'(1);
                acc_next          = '0;
                crc_next          = crc_byte;
                if (rx_byte == acfp_pkg::CHAR_COLON) begin
                  colons_next = colons + CW'(1);
                end
                if (rx_byte == acfp_pkg::CHAR_C) begin
                  digits_left_next = acfp_pkg::CSUM_DIGITS;
                  phase_next       = acfp_pkg::PH_CSUM;
                end
              end
            end else if (is_digit) begin
              if (acc_x10d[19:16] != 4'd0) begin
                phase_next = acfp_pkg::PH_BAD;
              end else begin
                acc_next = acc_x10d[15:0];
                crc_next = crc_byte;
              end
            end else begin
              phase_next = acfp_pkg::PH_BAD;
            end
          end
          acfp_pkg::PH_CSUM: begin
            if (!is_digit) begin
              phase_next = acfp_pkg::PH_BAD;
            end else begin
              acc_next         = acc_x10d[15:0];
              digits_left_next = digits_left - 2'd1;
              if (digits_left_next == 2'd0) begin
                phase_next = (acc_next == {8'b0, crc}) ? acfp_pkg::PH_EOL : acfp_pkg::PH_BAD;
              end
            end
          end
          acfp_pkg::PH_EOL: begin
            if (rx_byte == acfp_pkg::CHAR_LF) begin
              phase_next = acfp_pkg::PH_WAIT;
              done.start = 1'b1;
            end else if (rx_byte != acfp_pkg::CHAR_CR) begin
              phase_next = acfp_pkg::PH_BAD;
            end
          end
          default: begin
            phase_next = acfp_pkg::PH_BAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= acfp_pkg::PH_WAIT;
      acc          <= '0;
      digits_left  <= '0;
      crc          <= '0;
      cmd          <= '0;
      stored_count <= '0;
      colons       <= '0;
      addressed    <= 1'b0;
      idle_ticks   <= '0;
    end else begin
      phase        <= phase_next;
      acc          <= acc_next;
      digits_left  <= digits_left_next;
      crc          <= crc_next;
      cmd          <= cmd_next;
      stored_count <= stored_count_next;
      colons       <= colons_next;
      addressed    <= addressed_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

endmodule

[src/acfp_drain.sv]
module acfp_drain #(
  parameter int CW = 5,
  parameter int AW = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  acfp_pkg::frame_done_t done,
  input  logic [CW-1:0]         value_count,
  output logic                  idle,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [7:0]            mem_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [30:0]           out_payload,
  output logic                  out_last
);

  acfp_pkg::drain_state_t state, state_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic          load;
  logic          is_last;
  logic [7:0]    command;
  logic [3:0]    value_index;
  logic [7:0]    value;
  logic [4:0]    count_out;
  logic [4:0]    colon_count;
  logic          to_this_device;

  assign is_last   = (rd_idx + CW'(1)) == value_count;
  assign mem_raddr = rd_idx[AW-1:0];
  assign idle      = state == acfp_pkg::DR_IDLE;

  always_comb begin
    state_next  = state;
    rd_idx_next = rd_idx;
    mem_re      = 1'b0;
    load        = 1'b0;
    case (state)
      acfp_pkg::DR_IDLE: begin
        if (done.start) begin
          rd_idx_next = '0;
          state_next  = acfp_pkg::DR_READ;
        end
      end
      acfp_pkg::DR_READ: begin
        if (!out_valid || out_ready) begin
          mem_re     = 1'b1;
          state_next = acfp_pkg::DR_LOAD;
        end
      end
      acfp_pkg::DR_LOAD: begin
        load        = 1'b1;
        rd_idx_next = rd_idx + CW'(1);
        state_next  = is_last ? acfp_pkg::DR_IDLE : acfp_pkg::DR_READ;
      end
      default: begin
        state_next = acfp_pkg::DR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= acfp_pkg::DR_IDLE;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command        <= done.command;
      value_index    <= 4'(rd_idx);
      value          <= mem_rdata;
      count_out      <= 5'(value_count);
      colon_count    <= done.colon_count;
      to_this_device <= done.to_this_device;
      out_last       <= is_last;
    end
  end

  assign out_payload = {to_this_device, colon_count, count_out, value, value_index, command};

endmodule

[src/addressed_command_frame_parser_top.sv]
// channel  | direction | beat contents
// s_*      | in        | tdata received byte, tuser item kind (1 = tick)
// m_*      | out       | tdata one stored value with frame fields, tlast on final value
// cfg_*    | in        | cfg_index register number, cfg_data write data
//
// a byte or tick item is taken on s_tvalid with s_tready; s_tready stays high while parsing
// after the closing LF each value comes out of the value memory in a read state then a
// load state, so s_tready stays low until the final value is loaded, longer on m_* stalls
// rst is synchronous; the value memory has no clear, only entries of the frame are read
// the output register lets the next byte in while the final value waits
module addressed_command_frame_parser_top #(
  parameter int MAX_VALUES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // command, value_index, value, value_count, colon_count,
                                 // to_this_device
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam int AW = $clog2(MAX_VALUES);

  logic [6:0]  device_address;
  logic [15:0] timeout_ticks;
  logic        accept;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]  mem_wdata;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]  mem_rdata;
  logic [CW-1:0] value_count;
  logic        drain_idle;
  logic [30:0] out_payload;
  acfp_pkg::frame_done_t done;

  assign cfg_ready = 1'b1;
  assign s_tready  = drain_idle;
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = {1'b0, out_payload};

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= acfp_pkg::DEVICE_ADDRESS_RESET;
      timeout_ticks  <= acfp_pkg::TIMEOUT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        acfp_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        acfp_pkg::REG_TIMEOUT_TICKS:  timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  acfp_parser #(.MAX_VALUES(MAX_VALUES), .CW(CW), .AW(AW)) u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .func           (s_tuser),
    .rx_byte        (s_tdata),
    .device_address (device_address),
    .timeout_ticks  (timeout_ticks),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .done           (done),
    .value_count    (value_count)
  );

  acfp_mem #(.DEPTH(MAX_VALUES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  acfp_drain #(.CW(CW), .AW(AW)) u_drain (
    .clk         (clk),
    .rst         (rst),
    .done        (done),
    .value_count (value_count),
    .idle        (drain_idle),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_payload (out_payload),
    .out_last    (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("value memory written and read in one cycle");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    done.start |=> !s_tready)
    else $error("input still taken after frame end");

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (!m_tvalid || m_tready))
    else $error("value read while output register is held");
`endif

endmodule
